[rtl/sal_pkg.sv]
// Shared types, sizes and helpers for the set-associative LRU tag lookup.
`default_nettype none

package sal_pkg;

  localparam int unsigned WAYS      = 4;
  localparam int unsigned SET_BITS  = 8;
  localparam int unsigned NUM_SETS  = 1 << SET_BITS;
  localparam int unsigned SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned PC_W      = 32;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned WAY_OUT_W = 4;
  localparam int unsigned AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [0:0] {
    REG_OFFSET_BITS = 1'b0,
    REG_INDEX_BITS  = 1'b1
  } cfg_reg_e;

  // One memory row holds every way of a set.
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            vld;
  } sal_row_t;

  // Contents of a set that has not been written since reset.
  function automatic sal_row_t reset_row();
    sal_row_t r;
    r = '0;
    for (int j = 0; j < WAYS; j++) begin
      r.age[j] = AGE_W'(WAYS - 1 - j);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sal_in_if.sv]
// Input channel carrying one lookup address per item.
`default_nettype none

interface sal_in_if
  import sal_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] fetch_pc;

  modport source (output valid, output fetch_pc, input ready);
  modport sink   (input valid, input fetch_pc, output ready);
endinterface

`default_nettype wire

[rtl/sal_out_if.sv]
// Output channel carrying one hit or miss result per item.
`default_nettype none

interface sal_out_if
  import sal_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 miss;
  logic [WAY_OUT_W-1:0] way_used;

  modport source (output valid, output miss, output way_used, input ready);
  modport sink   (input valid, input miss, input way_used, output ready);
endinterface

`default_nettype wire

[rtl/set_assoc_lru_tag_lookup.sv]
// Set-associative tag lookup with true LRU replacement for a branch target buffer.
//
// Each item on in_i carries a program counter address. The low offset_bits are
// dropped, the next index_bits (at most SET_BITS) select a set and the rest is
// the tag. Each item yields one item on out_o: miss is low on a hit, and
// way_used names the way that hit or was filled on a miss.
// One set row (tags, ages, valid flags of all ways) lives in a synchronous
// memory. An accepted item reads its row into a register at accept; once the
// output register is free, the row is compared, updated and written back, and
// the result is loaded into the output register. A new item is accepted only
// once the previous one has been written back and the block is idle again;
// the row memory port pair serves the read and the write-back of one item.
// Reset clears the per-set written flags at once, so every set reads as its
// reset contents with no clearing pass; the registers return to offset 2 and
// index 8. While out_o stalls, a finished result waits in the output register
// and one further item may be accepted; its update waits until the output
// register is free. Configuration writes are taken on any cycle with cfg_we_i.
`default_nettype none

module set_assoc_lru_tag_lookup
  import sal_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  sal_in_if.sink                in_i,
  sal_out_if.source             out_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     offset_q;
  logic [CFG_W-1:0]     index_q;
  logic [TAG_W-1:0]     tag_q;
  logic [SET_W-1:0]     set_q;
  sal_row_t             rdata_q;
  logic                 rvld_q;
  logic [NUM_SETS-1:0]  written_q;
  logic                 out_valid_q;
  logic                 miss_q;
  logic [WAY_OUT_W-1:0] way_q;

  sal_row_t             mem [NUM_SETS];

  logic                 accept;
  logic                 finish;
  logic [TAG_W-1:0]     tag_d;
  logic [SET_W-1:0]     set_d;
  logic                 hit;
  logic [WAY_W-1:0]     sel_way;
  sal_row_t             new_row;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign accept         = in_i.valid && in_i.ready;
  assign finish         = (state_q == ST_LOOKUP) && (!out_valid_q || out_o.ready);
  assign out_o.valid    = out_valid_q;
  assign out_o.miss     = miss_q;
  assign out_o.way_used = way_q;

  // Split the address into set index and tag.
  always_comb begin
    logic [PC_W-1:0]  block;
    logic [CFG_W-1:0] ib;
    block = in_i.fetch_pc >> offset_q;
    ib    = (index_q > CFG_W'(SET_BITS)) ? CFG_W'(SET_BITS) : index_q;
    tag_d = TAG_W'(block >> ib);
    for (int k = 0; k < SET_W; k++) begin
      set_d[k] = block[k] && (CFG_W'(k) < ib);
    end
  end

  // Lookup, victim choice and age update on the row read at accept.
  always_comb begin
    sal_row_t         row;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic [AGE_W-1:0] old_age;
    row     = rvld_q ? rdata_q : reset_row();
    hit     = 1'b0;
    hit_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (row.vld[j] && (row.tag[j] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(j);
      end
    end
    victim = '0;
    for (int j = 1; j < WAYS; j++) begin
      if (row.age[j] > row.age[victim]) begin
        victim = WAY_W'(j);
      end
    end
    sel_way = hit ? hit_way : victim;
    old_age = row.age[sel_way];
    new_row = row;
    for (int j = 0; j < WAYS; j++) begin
      if (row.age[j] < old_age) begin
        new_row.age[j] = row.age[j] + AGE_W'(1);
      end
    end
    new_row.age[sel_way] = '0;
    if (!hit) begin
      new_row.tag[sel_way] = tag_q;
      new_row.vld[sel_way] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      mem[set_q] <= new_row;
    end
    if (accept) begin
      rdata_q <= mem[set_d];
      tag_q   <= tag_d;
      set_q   <= set_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      offset_q    <= CFG_W'(2);
      index_q     <= CFG_W'(8);
      written_q   <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      miss_q      <= 1'b0;
      way_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_OFFSET_BITS: offset_q <= cfg_data_i;
          REG_INDEX_BITS:  index_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        rvld_q <= written_q[set_d];
      end
      if (finish) begin
        written_q[set_q] <= 1'b1;
        out_valid_q      <= 1'b1;
        miss_q           <= !hit;
        way_q            <= WAY_OUT_W'(sel_way);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
